FILE: hdl/bpm_pkg.sv
// shared constants, types and helpers for the byte pattern matcher
package bpm_pkg;

    // window depth in cells, one pattern byte per cell
    localparam int PATTERN_BYTES = 16;
    localparam int LEN_W         = $clog2(PATTERN_BYTES + 1);
    localparam int WIN_IDX_W     = $clog2(PATTERN_BYTES);

    // bytes carried by the two pattern registers
    localparam int REG_PATTERN_BYTES = 16;
    localparam int PATTERN_W         = 8 * REG_PATTERN_BYTES;

    // field widths
    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = 32;
    localparam int COUNT_W   = 16;
    localparam int CFG_LEN_W = 5;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;

    // stream payload widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 2'd0,
        REG_PATTERN_HIGH = 2'd1,
        REG_PATTERN_LEN  = 2'd2,
        REG_MAX_HITS     = 2'd3
    } cfg_reg_t;

    // data passed from one cell to the next
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              valid;
    } cell_link_t;

    // pattern byte k, bytes past the registers read as zero
    function automatic logic [BYTE_W-1:0] pattern_byte(
        input logic [PATTERN_W-1:0] pat,
        input logic [LEN_W-1:0]     k
    );
        logic [BYTE_W-1:0] b;
        b = '0;
        if (32'(k) < REG_PATTERN_BYTES) begin
            b = pat[{k[$clog2(REG_PATTERN_BYTES)-1:0], 3'b000} +: BYTE_W];
        end
        return b;
    endfunction

endpackage

FILE: hdl/byte_pattern_matcher.sv
// top level: exact byte pattern search over a chain of window cells
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------------
//  s_       | in        | tdata: byte_value, byte_address; tuser: chunk/scan
//  m_       | out       | tdata: hit_address, hit_count; tuser: limit_reached
//  cfg_     | in        | register index and write data, no read-back
//
// one byte is taken per cycle while s_tready is high; a hit shows on m_tvalid
// via the output register; window cells shift on accept, compare in parallel.
// reset clears the window, the hit count and the pipeline valids, and loads
// pattern length 1 and max hits 1.
// a stalled result holds in the output register; the compare stage keeps
// taking bytes that give no hit and waits only when it holds a hit itself.
module byte_pattern_matcher (
    input  logic                            aclk,
    input  logic                            aresetn,
    // byte_value [7:0], byte_address [39:8]
    input  logic [bpm_pkg::S_TDATA_W-1:0]   s_tdata,
    // chunk_start [0], scan_start [1]
    input  logic [bpm_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // hit_address [31:0], hit_count [47:32]
    output logic [bpm_pkg::M_TDATA_W-1:0]   m_tdata,
    // limit_reached [0]
    output logic [bpm_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_wr_en,
    input  logic [bpm_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [bpm_pkg::CFG_W-1:0]       cfg_wr_data
);
    import bpm_pkg::*;

    // configuration registers
    logic [PATTERN_W-1:0] pattern_reg;
    logic [CFG_LEN_W-1:0] pat_len_reg;
    logic [COUNT_W-1:0]   max_hits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg  <= '0;
            pat_len_reg  <= CFG_LEN_W'(1);
            max_hits_reg <= COUNT_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_PATTERN_LOW:  pattern_reg[CFG_W-1:0]         <= cfg_wr_data;
                REG_PATTERN_HIGH: pattern_reg[PATTERN_W-1:CFG_W] <= cfg_wr_data;
                REG_PATTERN_LEN:  pat_len_reg  <= cfg_wr_data[CFG_LEN_W-1:0];
                REG_MAX_HITS:     max_hits_reg <= cfg_wr_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // effective length, saturated to the window depth
    logic [LEN_W-1:0] len_eff;
    logic             len_nz;
    always_comb begin
        if (32'(pat_len_reg) > PATTERN_BYTES) begin
            len_eff = LEN_W'(PATTERN_BYTES);
        end else begin
            len_eff = LEN_W'(pat_len_reg);
        end
    end
    assign len_nz = (len_eff != '0);

    // input unpacking
    logic [BYTE_W-1:0] in_byte;
    logic [ADDR_W-1:0] in_addr;
    logic              in_chunk;
    logic              in_scan;
    assign in_byte  = s_tdata[BYTE_W-1:0];
    assign in_addr  = s_tdata[BYTE_W +: ADDR_W];
    assign in_chunk = s_tuser[0];
    assign in_scan  = s_tuser[1];

    // handshake and stage control
    logic s_accept;
    logic a_move;
    logic hit;
    logic a_valid_reg;
    logic a_valid_next;
    logic o_valid_reg;
    logic o_valid_next;

    assign a_move   = a_valid_reg & (~hit | ~o_valid_reg | m_tready);
    assign s_tready = ~a_valid_reg | a_move;
    assign s_accept = s_tvalid & s_tready;

    // chain of window cells, cell 0 holds the newest byte
    cell_link_t                    link [PATTERN_BYTES+1];
    logic [PATTERN_BYTES-1:0]      cell_match;
    logic [PATTERN_BYTES-1:0]      win_valid;

    assign link[0].data  = in_byte;
    assign link[0].valid = 1'b1;

    for (genvar i = 0; i < PATTERN_BYTES; i++) begin : g_cell
        logic              in_use;
        logic [LEN_W-1:0]  pat_idx;
        logic [BYTE_W-1:0] pat_b;
        logic              clr;

        // cell i pairs with pattern byte len - 1 - i
        assign in_use  = (32'(len_eff) > i);
        assign pat_idx = LEN_W'(len_eff - LEN_W'(i + 1));
        assign pat_b   = pattern_byte(pattern_reg, pat_idx);
        assign clr     = (i == 0) ? 1'b0 : in_chunk;

        bpm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (s_accept),
            .clear    (clr),
            .link_in  (link[i]),
            .pat_byte (pat_b),
            .in_use   (in_use),
            .link_out (link[i+1]),
            .match    (cell_match[i])
        );

        assign win_valid[i] = link[i+1].valid;
    end

    // side data of the byte now in cell 0
    logic [ADDR_W-1:0] a_addr_reg;
    logic              a_scan_reg;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_accept) begin
            a_valid_next = 1'b1;
        end else if (a_move) begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
        if (s_accept) begin
            a_addr_reg <= in_addr;
            a_scan_reg <= in_scan;
        end
    end

    // hit decision and running count
    logic [COUNT_W-1:0] hits_reg;
    logic [COUNT_W-1:0] hits_next;
    logic [COUNT_W-1:0] hits_base;
    logic [COUNT_W-1:0] hits_inc;
    logic [ADDR_W-1:0]  hit_addr;

    assign hits_base = a_scan_reg ? '0 : hits_reg;
    assign hits_inc  = hits_base + COUNT_W'(1);
    assign hit       = a_valid_reg & len_nz & (&cell_match) & (hits_base < max_hits_reg);
    assign hit_addr  = a_addr_reg - ADDR_W'(len_eff - LEN_W'(1));

    always_comb begin
        hits_next = hits_reg;
        if (a_move) begin
            hits_next = hit ? hits_inc : hits_base;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hits_reg <= '0;
        end else begin
            hits_reg <= hits_next;
        end
    end

    // output register
    logic                 o_load;
    logic [ADDR_W-1:0]    o_addr_reg;
    logic [COUNT_W-1:0]   o_count_reg;
    logic                 o_limit_reg;

    assign o_load = a_move & hit;

    always_comb begin
        o_valid_next = o_valid_reg;
        if (o_load) begin
            o_valid_next = 1'b1;
        end else if (m_tready) begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else begin
            o_valid_reg <= o_valid_next;
        end
        if (o_load) begin
            o_addr_reg  <= hit_addr;
            o_count_reg <= hits_inc;
            o_limit_reg <= (hits_inc == max_hits_reg);
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {o_count_reg, o_addr_reg};
    assign m_tuser  = o_limit_reg;

    // checks
    a_valid_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot({1'b0, win_valid} + (PATTERN_BYTES + 1)'(1)))
        else $error("window valid bits not contiguous from the newest cell");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:ADDR_W] != '0) &&
                     (m_tdata[M_TDATA_W-1:ADDR_W] <= max_hits_reg))
        else $error("hit count outside one to max hits");

    a_limit_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] == (m_tdata[M_TDATA_W-1:ADDR_W] == max_hits_reg)))
        else $error("limit flag disagrees with hit count");

    a_hit_needs_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        hit |-> win_valid[WIN_IDX_W'(len_eff - LEN_W'(1))])
        else $error("hit reported before the window holds the pattern length");

endmodule

FILE: hdl/bpm_cell.sv
// one window cell: holds a byte, shifts it on, compares it to its pattern byte
module bpm_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      shift_en,
    input  logic                      clear,
    input  bpm_pkg::cell_link_t       link_in,
    input  logic [bpm_pkg::BYTE_W-1:0] pat_byte,
    input  logic                      in_use,
    output bpm_pkg::cell_link_t       link_out,
    output logic                      match
);
    import bpm_pkg::*;

    logic [BYTE_W-1:0] data_reg;
    logic              valid_reg;
    logic [BYTE_W-1:0] data_next;
    logic              valid_next;

    // take the neighbor's byte on every shift, a chunk start empties the cell
    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (shift_en) begin
            data_next  = link_in.data;
            valid_next = link_in.valid & ~clear;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign link_out.data  = data_reg;
    assign link_out.valid = valid_reg;

    // cells beyond the pattern length always agree
    assign match = ~in_use | (valid_reg & (data_reg == pat_byte));

endmodule
